FILE: design/wrrp_pkg.sv
// shared constants, types and helpers for the weighted round-robin picker
package wrrp_pkg;

  localparam int SERVER_COUNT = 8;
  localparam int WEIGHT_BITS  = 8;
  localparam int IDX_W        = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;
  localparam int MASK_W       = 8;
  localparam int ID_W         = 3;
  localparam int AVAIL_N      = (SERVER_COUNT < MASK_W) ? SERVER_COUNT : MASK_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERVER_COUNT - 1);

  localparam logic ACT_SELECT = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [WEIGHT_BITS-1:0] wgt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_REFILL,
    ST_ISSUE,
    ST_DONE
  } state_t;

  // cyclic successor of a server index
  function automatic idx_t next_idx(idx_t i);
    next_idx = (i == LAST_IDX) ? '0 : i + idx_t'(1);
  endfunction

  // servers beyond the mask count as unavailable
  function automatic logic is_avail(logic [MASK_W-1:0] m, idx_t i);
    logic a;
    a = 1'b0;
    for (int k = 0; k < AVAIL_N; k++) begin
      if (i == IDX_W'(k)) a = m[k];
    end
    is_avail = a;
  endfunction

  // credit refill, saturating at all ones
  function automatic wgt_t sat_add(wgt_t c, wgt_t w);
    logic [WEIGHT_BITS:0] s;
    s = {1'b0, c} + {1'b0, w};
    sat_add = s[WEIGHT_BITS] ? '1 : s[WEIGHT_BITS-1:0];
  endfunction

endpackage

FILE: design/weighted_round_robin_pick_core.sv
// weighted round-robin picker: credit and weight memories with a walking sequencer
//
//  channel | direction | word
//  in      | input     | action, available_mask, server_id, weight_value
//  out     | output    | chosen_server, found
//
// a load passes from accept through the done state to the output register; a select
// walks the servers, a credit read-modify-write per nonzero credit visited, up to
// two circles, with a refill sweep through the credit and weight memories and one reread
// one word is in work at a time; in_ready returns once the result is in the
// output register, so the next word can enter while that result waits
// rst is synchronous; credits and weights read as zero after it, and the last pick returns to the last server
module weighted_round_robin_pick_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] available_mask,
  input  logic [2:0] server_id,
  input  logic [7:0] weight_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] chosen_server,
  output logic       found
);

  wrrp_pkg::state_t state, state_next;
  wrrp_pkg::idx_t   p, p_next;
  wrrp_pkg::idx_t   start_idx, start_next;
  wrrp_pkg::idx_t   rf_idx, rf_idx_next;
  wrrp_pkg::idx_t   last_pick, last_pick_next;
  logic             refilled, refilled_next;
  logic             just_refilled, just_refilled_next;
  logic [wrrp_pkg::MASK_W-1:0] mask, mask_next;
  logic [wrrp_pkg::ID_W-1:0]   res_server, res_server_next;
  logic             res_found, res_found_next;

  // memories
  wrrp_pkg::wgt_t   credit_mem [wrrp_pkg::SERVER_COUNT];
  wrrp_pkg::wgt_t   weight_mem [wrrp_pkg::SERVER_COUNT];
  logic [wrrp_pkg::SERVER_COUNT-1:0] cred_vld, wgt_vld;
  wrrp_pkg::wgt_t   cred_rd, wgt_rd;
  logic             cred_rd_vld, wgt_rd_vld;
  wrrp_pkg::wgt_t   cred_cur, wgt_cur;

  wrrp_pkg::idx_t   rd_addr;
  logic             cred_we;
  wrrp_pkg::idx_t   cred_waddr;
  wrrp_pkg::wgt_t   cred_wdata;
  logic             wgt_we;
  wrrp_pkg::idx_t   wgt_waddr;
  logic             in_acc, out_load, here_avail;

  assign in_ready = (state == wrrp_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == wrrp_pkg::ST_DONE) && (!out_valid || out_ready);

  assign wgt_we    = in_acc && (action == wrrp_pkg::ACT_LOAD)
                     && (int'(server_id) < wrrp_pkg::SERVER_COUNT);
  assign wgt_waddr = wrrp_pkg::IDX_W'(server_id);

  // entries never written read as zero
  assign cred_cur   = cred_rd_vld ? cred_rd : '0;
  assign wgt_cur    = wgt_rd_vld ? wgt_rd : '0;
  assign here_avail = wrrp_pkg::is_avail(mask, p);

  always_ff @(posedge clk) begin
    if (cred_we) begin
      credit_mem[cred_waddr] <= cred_wdata;
    end
    if (wgt_we) begin
      weight_mem[wgt_waddr] <= wrrp_pkg::WEIGHT_BITS'(weight_value);
    end
    cred_rd <= credit_mem[rd_addr];
    wgt_rd  <= weight_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cred_vld    <= '0;
      wgt_vld     <= '0;
      cred_rd_vld <= 1'b0;
      wgt_rd_vld  <= 1'b0;
    end else begin
      if (cred_we) cred_vld[cred_waddr] <= 1'b1;
      if (wgt_we) wgt_vld[wgt_waddr] <= 1'b1;
      cred_rd_vld <= cred_vld[rd_addr];
      wgt_rd_vld  <= wgt_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wrrp_pkg::ST_IDLE;
      last_pick <= wrrp_pkg::LAST_IDX;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      last_pick <= last_pick_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p             <= p_next;
    start_idx     <= start_next;
    rf_idx        <= rf_idx_next;
    refilled      <= refilled_next;
    just_refilled <= just_refilled_next;
    mask          <= mask_next;
    res_server    <= res_server_next;
    res_found     <= res_found_next;
    if (out_load) begin
      chosen_server <= res_server;
      found         <= res_found;
    end
  end

  always_comb begin
    state_next         = state;
    p_next             = p;
    start_next         = start_idx;
    rf_idx_next        = rf_idx;
    refilled_next      = refilled;
    just_refilled_next = just_refilled;
    mask_next          = mask;
    last_pick_next     = last_pick;
    res_server_next    = res_server;
    res_found_next     = res_found;
    rd_addr            = p;
    cred_we            = 1'b0;
    cred_waddr         = p;
    cred_wdata         = cred_cur - wrrp_pkg::wgt_t'(1);

    case (state)
      wrrp_pkg::ST_IDLE: begin
        rd_addr = wrrp_pkg::next_idx(last_pick);
        if (in_valid) begin
          if (action == wrrp_pkg::ACT_LOAD) begin
            res_server_next = '0;
            res_found_next  = 1'b0;
            state_next      = wrrp_pkg::ST_DONE;
          end else begin
            start_next         = last_pick;
            p_next             = wrrp_pkg::next_idx(last_pick);
            refilled_next      = 1'b0;
            just_refilled_next = 1'b0;
            mask_next          = available_mask;
            state_next         = wrrp_pkg::ST_WALK;
          end
        end
      end

      wrrp_pkg::ST_WALK: begin
        // prefetch the next server while this one is updated
        rd_addr            = wrrp_pkg::next_idx(p);
        p_next             = wrrp_pkg::next_idx(p);
        just_refilled_next = 1'b0;
        if (p == start_idx) begin
          if (cred_cur == '0) begin
            if (refilled) begin
              // right after the refill an empty start walks one more circle
              if (!just_refilled) begin
                res_server_next = '0;
                res_found_next  = 1'b0;
                last_pick_next  = wrrp_pkg::LAST_IDX;
                state_next      = wrrp_pkg::ST_DONE;
              end
            end else begin
              p_next      = p;
              rf_idx_next = '0;
              rd_addr     = '0;
              state_next  = wrrp_pkg::ST_REFILL;
            end
          end else begin
            cred_we         = 1'b1;
            res_found_next  = here_avail;
            res_server_next = here_avail ? wrrp_pkg::ID_W'(p) : '0;
            last_pick_next  = here_avail ? p : wrrp_pkg::LAST_IDX;
            state_next      = wrrp_pkg::ST_DONE;
          end
        end else if (cred_cur != '0) begin
          cred_we = 1'b1;
          if (here_avail) begin
            res_found_next  = 1'b1;
            res_server_next = wrrp_pkg::ID_W'(p);
            last_pick_next  = p;
            state_next      = wrrp_pkg::ST_DONE;
          end
        end
      end

      wrrp_pkg::ST_REFILL: begin
        cred_we    = 1'b1;
        cred_waddr = rf_idx;
        cred_wdata = wrrp_pkg::sat_add(cred_cur, wgt_cur);
        if (rf_idx == wrrp_pkg::LAST_IDX) begin
          // start may equal the entry written now, so reread it next cycle
          state_next = wrrp_pkg::ST_ISSUE;
        end else begin
          rf_idx_next = rf_idx + wrrp_pkg::idx_t'(1);
          rd_addr     = rf_idx + wrrp_pkg::idx_t'(1);
        end
      end

      wrrp_pkg::ST_ISSUE: begin
        rd_addr            = p;
        refilled_next      = 1'b1;
        just_refilled_next = 1'b1;
        state_next         = wrrp_pkg::ST_WALK;
      end

      wrrp_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = wrrp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = wrrp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/wrrp_checker.sv
// port-level checks for the weighted round-robin picker, bound to the top level
module wrrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       action,
  input logic [7:0] available_mask,
  input logic [2:0] server_id,
  input logic [7:0] weight_value,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] chosen_server,
  input logic       found
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_server) && $stable(found))
    else $error("stalled result word changed");

  // a result without a pick reports server zero
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> chosen_server == 3'd0)
    else $error("result without a pick names a server");

  // one word in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind weighted_round_robin_pick_core wrrp_checker u_wrrp_checker (.*);
